// ----- src/tsm_pkg.sv -----
// tsm_pkg: shared types and constants for the term sort and merge block
// no dependencies
package tsm_pkg;

    localparam int unsigned COEF_W = 32;
    localparam int unsigned EXP_W  = 16;
    localparam int unsigned SUM_W  = 40;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COEF_W-1:0] term_coefficient;
        logic signed [EXP_W-1:0]  term_exponent;
        logic                     group_end;
    } term_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_coefficient;
        logic signed [EXP_W-1:0] sum_exponent;
        logic                    run_last;
        logic                    terms_dropped;
    } term_out_t;

    // saturating add of a coefficient into a 40-bit sum
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  a,
        input logic signed [COEF_W-1:0] b
    );
        logic signed [SUM_W:0] r;
        begin
            r = {a[SUM_W-1], a} + {{(SUM_W+1-COEF_W){b[COEF_W-1]}}, b};
            if (r[SUM_W] != r[SUM_W-1])
                sat_add = r[SUM_W] ? SUM_MIN : SUM_MAX;
            else
                sat_add = r[SUM_W-1:0];
        end
    endfunction

endpackage

// ----- src/tsm_front.sv -----
// tsm_front: accepts term words into a one-entry queue toward the store
// depends on tsm_pkg
module tsm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tsm_pkg::term_in_t din,
    output logic              busy,
    output logic              q_valid,
    output tsm_pkg::term_in_t q_word,
    input  logic              q_take
);
    logic              full_reg;
    logic              full_next;
    tsm_pkg::term_in_t word_reg;

    assign busy      = full_reg;
    assign q_valid   = full_reg;
    assign q_word    = word_reg;
    assign full_next = (start && !full_reg) ? 1'b1 : (q_take ? 1'b0 : full_reg);

    // queue slot control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (start && !full_reg)
            word_reg <= din;
    end
endmodule

// ----- src/tsm_back.sv -----
// tsm_back: sorted insertion store with merge and ordered emit
// depends on tsm_pkg
module tsm_back #(
    parameter int unsigned MAX_TERMS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  tsm_pkg::term_in_t  q_word,
    output logic               q_take,
    output logic               done,
    output tsm_pkg::term_out_t result
);
    localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);
    localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    typedef enum logic [1:0] {ST_LOAD, ST_INS, ST_EMIT} state_t;

    state_t                          state_reg;
    logic [CNT_W-1:0]                used_reg;
    logic                            ovf_reg;
    logic                            last_reg;
    logic [IDX_W-1:0]                emit_reg;
    logic                            done_reg;
    tsm_pkg::term_out_t              result_reg;
    logic signed [tsm_pkg::EXP_W-1:0]  exps_reg [MAX_TERMS];
    logic signed [tsm_pkg::SUM_W-1:0]  sums_reg [MAX_TERMS];
    logic signed [tsm_pkg::COEF_W-1:0] coef_reg;
    logic signed [tsm_pkg::EXP_W-1:0]  exp_reg;

    // per-entry compare: greater and equal flags, registered word from the queue
    logic [MAX_TERMS-1:0] gt;
    logic [MAX_TERMS-1:0] eq;
    logic [MAX_TERMS-1:0] act;
    logic                 any_eq;
    logic                 full;

    always_comb
    begin
        for (int k = 0; k < MAX_TERMS; k++)
        begin
            act[k] = (k < used_reg);
            gt[k]  = act[k] && (exps_reg[k] > exp_reg);
            eq[k]  = act[k] && (exps_reg[k] == exp_reg);
        end
    end
    assign any_eq = |eq;
    assign full   = (used_reg == CNT_W'(MAX_TERMS));
    assign q_take = (state_reg == ST_LOAD) && q_valid;
    assign done   = done_reg;
    assign result = result_reg;

    // control and emit outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            used_reg  <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
            emit_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_LOAD:
                begin
                    if (q_valid)
                    begin
                        last_reg  <= q_word.group_end;
                        state_reg <= ST_INS;
                    end
                end
                ST_INS:
                begin
                    if (!any_eq)
                    begin
                        if (full)
                            ovf_reg <= 1'b1;
                        else
                            used_reg <= used_reg + 1'b1;
                    end
                    emit_reg  <= '0;
                    state_reg <= last_reg ? ST_EMIT : ST_LOAD;
                end
                ST_EMIT:
                begin
                    done_reg <= 1'b1;
                    if ({1'b0, emit_reg} + 1'b1 == (CNT_W+1)'(used_reg))
                    begin
                        used_reg  <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                    else
                        emit_reg <= emit_reg + 1'b1;
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT)
        begin
            result_reg.sum_coefficient <= sums_reg[emit_reg];
            result_reg.sum_exponent    <= exps_reg[emit_reg];
            result_reg.run_last        <= ({1'b0, emit_reg} + 1'b1 == (CNT_W+1)'(used_reg));
            result_reg.terms_dropped   <= ovf_reg;
        end
    end

    // term register and store: merge in place or shift entries down one slot
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            coef_reg <= q_word.term_coefficient;
            exp_reg  <= q_word.term_exponent;
        end
        if (state_reg == ST_INS)
        begin
            for (int k = 0; k < MAX_TERMS; k++)
            begin
                if (any_eq)
                begin
                    if (eq[k])
                        sums_reg[k] <= tsm_pkg::sat_add(sums_reg[k], coef_reg);
                end
                else if (!full && !gt[k] && k <= used_reg)
                begin
                    if (k == 0 || gt[(k > 0) ? k-1 : 0])
                    begin
                        exps_reg[k] <= exp_reg;
                        sums_reg[k] <= {{(tsm_pkg::SUM_W-tsm_pkg::COEF_W){coef_reg[tsm_pkg::COEF_W-1]}},
                                        coef_reg};
                    end
                    else
                    begin
                        exps_reg[k] <= exps_reg[(k > 0) ? k-1 : 0];
                        sums_reg[k] <= sums_reg[(k > 0) ? k-1 : 0];
                    end
                end
            end
        end
    end
endmodule

// ----- src/term_sort_and_merge.sv -----
// term_sort_and_merge: combines like polynomial terms, emitted in descending exponent order
// depends on tsm_pkg, tsm_front, tsm_back
// flow: the group end word passes ST_LOAD and ST_INS, then ST_EMIT fills the result register
// each term is loaded, then inserted or merged in one shift step; the front queues the next
// term meanwhile, the store takes none while it emits; results come one per cycle, no stall
// reset: asynchronous active low, empties the queue and the store count
module term_sort_and_merge #(
    parameter int unsigned MAX_TERMS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tsm_pkg::term_in_t  din,
    output logic               busy,
    output logic               done,
    output tsm_pkg::term_out_t result
);
    logic              q_valid;
    logic              q_take;
    tsm_pkg::term_in_t q_word;

    // front: word intake
    tsm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .din     (din),
        .busy    (busy),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_take  (q_take)
    );

    // back: sorted store and emit
    tsm_back #(.MAX_TERMS(MAX_TERMS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_take  (q_take),
        .done    (done),
        .result  (result)
    );
endmodule

// ----- test/term_sort_and_merge_checker.sv -----
// term_sort_and_merge_checker: predicts merged terms from accepted input words and compares
// depends on tsm_pkg; watches the ports of term_sort_and_merge
`timescale 1ns / 100ps

module term_sort_and_merge_checker #(
    parameter int unsigned MAX_TERMS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  tsm_pkg::term_in_t  din,
    input  logic               done,
    input  tsm_pkg::term_out_t result,
    output int                 fail_count,
    output int                 pending_terms
);
    logic signed [tsm_pkg::EXP_W-1:0] held_exp [MAX_TERMS];
    logic signed [tsm_pkg::SUM_W-1:0] held_sum [MAX_TERMS];
    int                               held_count;
    logic                             dropped_seen;
    tsm_pkg::term_out_t               merged_terms_q[$];

    // saturating accumulate, written independently of the package
    function automatic logic signed [tsm_pkg::SUM_W-1:0] accumulate(
        input logic signed [tsm_pkg::SUM_W-1:0]  acc,
        input logic signed [tsm_pkg::COEF_W-1:0] coef
    );
        longint r;
        begin
            r = longint'(acc) + longint'(coef);
            if (r > 64'sd549755813887)
                accumulate = 40'sh7F_FFFF_FFFF;
            else if (r < -64'sd549755813888)
                accumulate = 40'sh80_0000_0000;
            else
                accumulate = r[tsm_pkg::SUM_W-1:0];
        end
    endfunction

    // sorted insertion and group emission
    task automatic absorb_term(input tsm_pkg::term_in_t w);
        int pos;
        tsm_pkg::term_out_t o;
        begin
            pos = 0;
            while (pos < held_count && held_exp[pos] > w.term_exponent)
                pos++;
            if (pos < held_count && held_exp[pos] == w.term_exponent)
                held_sum[pos] = accumulate(held_sum[pos], w.term_coefficient);
            else if (held_count >= MAX_TERMS)
                dropped_seen = 1'b1;
            else
            begin
                for (int k = held_count; k > pos; k--)
                begin
                    held_exp[k] = held_exp[k-1];
                    held_sum[k] = held_sum[k-1];
                end
                held_exp[pos] = w.term_exponent;
                held_sum[pos] = {{(tsm_pkg::SUM_W-tsm_pkg::COEF_W){
                                     w.term_coefficient[tsm_pkg::COEF_W-1]}},
                                 w.term_coefficient};
                held_count++;
            end
            if (w.group_end)
            begin
                for (int k = 0; k < held_count; k++)
                begin
                    o.sum_coefficient = held_sum[k];
                    o.sum_exponent    = held_exp[k];
                    o.run_last        = (k == held_count - 1);
                    o.terms_dropped   = dropped_seen;
                    merged_terms_q.insert(merged_terms_q.size(), o);
                end
                held_count   = 0;
                dropped_seen = 1'b0;
            end
        end
    endtask

    assign pending_terms = merged_terms_q.size() + held_count;

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        tsm_pkg::term_out_t e;
        if (!rst_n)
        begin
            held_count   <= 0;
            dropped_seen <= 1'b0;
            fail_count   <= 0;
            merged_terms_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (merged_terms_q.size() == 0)
                begin
                    $error("result word with nothing expected: %p", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = merged_terms_q.pop_front();
                    if (result.sum_coefficient !== e.sum_coefficient)
                        $error("sum_coefficient expected %0d actual %0d",
                               e.sum_coefficient, result.sum_coefficient);
                    if (result.sum_exponent !== e.sum_exponent)
                        $error("sum_exponent expected %0d actual %0d",
                               e.sum_exponent, result.sum_exponent);
                    if (result.run_last !== e.run_last)
                        $error("run_last expected %0b actual %0b",
                               e.run_last, result.run_last);
                    if (result.terms_dropped !== e.terms_dropped)
                        $error("terms_dropped expected %0b actual %0b",
                               e.terms_dropped, result.terms_dropped);
                    if (result !== e)
                        fail_count <= fail_count + 1;
                end
            end
            if (start && !busy)
                absorb_term(din);
        end
    end

endmodule

// ----- test/term_sort_and_merge_tb.sv -----
// term_sort_and_merge_tb: directed and random term groups into term_sort_and_merge
// depends on tsm_pkg, term_sort_and_merge and term_sort_and_merge_checker
`timescale 1ns / 100ps

module term_sort_and_merge_tb;
    localparam int unsigned MAX_TERMS = 32;

    logic               clk;
    logic               rst_n;
    logic               start;
    tsm_pkg::term_in_t  din;
    logic               busy;
    logic               done;
    tsm_pkg::term_out_t result;
    int                 fail_count;
    int                 pending_terms;
    int                 burst_left;

    term_sort_and_merge #(.MAX_TERMS(MAX_TERMS)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .din(din),
        .busy(busy), .done(done), .result(result)
    );

    term_sort_and_merge_checker #(.MAX_TERMS(MAX_TERMS)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .din(din),
        .done(done), .result(result), .fail_count(fail_count),
        .pending_terms(pending_terms)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // send one word, then wait for acceptance; gaps come between some bursts
    task automatic send_term(input logic signed [31:0] coef,
                             input logic signed [15:0] expo, input logic last);
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            burst_left--;
            start <= 1'b1;
            din   <= '{term_coefficient: coef, term_exponent: expo, group_end: last};
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    task automatic random_group(input int n, input int expo_span);
        logic signed [31:0] c;
        logic signed [15:0] x;
        begin
            for (int i = 0; i < n; i++)
            begin
                c = $urandom;
                if (expo_span == 0)
                    x = 16'($urandom);
                else
                    x = 16'(int'($urandom_range(0, expo_span)) - expo_span / 2);
                send_term(c, x, i == n - 1);
            end
        end
    endtask

    initial
    begin
        int sent;
        int n;
        int span;
        rst_n      = 1'b0;
        start      = 1'b0;
        din        = '0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, merge to zero, single-term group
        send_term(32'sh7FFF_FFFF, 16'sh7FFF, 1'b0);
        send_term(32'sh8000_0000, 16'sh8000, 1'b0);
        send_term(32'sh0001_0000, 16'sh0000, 1'b0);
        send_term(-32'sh0001_0000, 16'sh0000, 1'b0);
        send_term(32'sh0000_0000, 16'sh8000, 1'b1);
        send_term(32'sh1234_5678, 16'sh0005, 1'b1);
        // positive saturation through repeats of one exponent
        for (int i = 0; i < 256; i++)
            send_term(32'sh7FFF_FFFF, 16'sh0003, 1'b0);
        send_term(32'sh7FFF_FFFF, 16'sh0003, 1'b1);
        // store full: 34 distinct exponents, then a merge into a held one
        for (int i = 0; i < 34; i++)
            send_term($urandom, 16'(i * 7 - 100), 1'b0);
        send_term(32'sh0000_0001, -16'sd100, 1'b1);
        sent = 298;

        // pause until every expected word has come out
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_terms != 0)
            @(posedge clk);

        // random groups, mostly small with clustered exponents
        while (sent < 340)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    n    = $urandom_range(30, 40);
                    span = $urandom_range(2, 60);
                end
                1, 2:
                begin
                    n    = $urandom_range(1, 10);
                    span = 0;
                end
                default:
                begin
                    n    = $urandom_range(1, 12);
                    span = $urandom_range(2, 60);
                end
            endcase
            random_group(n, span);
            sent += n;
        end

        start <= 1'b0;
        @(posedge clk);
        fork
            begin
                while (pending_terms != 0)
                    @(posedge clk);
                repeat (80) @(posedge clk);
            end
            begin
                repeat (200000) @(posedge clk);
                $display("timeout waiting for merged terms");
            end
        join_any
        if (pending_terms == 0 && fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
